@@ rtl/text_console_char_writer_macros.svh @@
// Assertion macros for the text console character writer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`ifndef ASSERT_OFF
`define TCCW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("console writer assertion failed");
`define TCCW_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("console writer assertion failed");
`else
`define TCCW_ASSERT(lbl, clk, rst_n, prop)
`define TCCW_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

@@ rtl/tccw_pkg.sv @@
`default_nettype none
package tccw_pkg;

	localparam int DATA_W      = 8;
	localparam int ADDR_W      = 11;
	localparam int CELL_W      = 16;
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [DATA_W-1:0] CH_BS    = 8'd8;
	localparam logic [DATA_W-1:0] CH_TAB   = 8'd9;
	localparam logic [DATA_W-1:0] CH_LF    = 8'd10;
	localparam logic [DATA_W-1:0] CH_CR    = 8'd13;
	localparam logic [DATA_W-1:0] CH_ESC   = 8'd27;
	localparam logic [DATA_W-1:0] CH_BEL   = 8'd7;
	localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		CC_PRINT,
		CC_BS,
		CC_TAB,
		CC_LF,
		CC_CR,
		CC_ESC,
		CC_BEL
	} char_class_t;

	typedef enum logic [2:0] {
		CUR_NONE,
		CUR_ADV,
		CUR_BACK,
		CUR_LF,
		CUR_CR,
		CUR_HOME,
		CUR_SCROLL
	} cur_op_t;

	typedef enum logic [1:0] {
		SW_NONE,
		SW_FILL_ALL,
		SW_FILL_ROW,
		SW_COPY
	} sweep_op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_PUT,
		ST_SCROLL_COPY,
		ST_SCROLL_ROW,
		ST_CLEAR,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic      load_item;
		cur_op_t   cur_op;
		logic      wr_char;
		logic      wr_space;
		logic      wr_blank_back;
		logic      rd_cell;
		logic      cap_read;
		sweep_op_t sweep;
		logic      out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic        op_read;
		char_class_t cclass;
		logic        addr_ok;
		logic        at_last_cell;
		logic        on_last_row;
		logic        sweep_busy;
		logic        out_free;
	} dp_sts_t;

	function automatic char_class_t char_class(input logic [DATA_W-1:0] c);
		char_class_t r;
		case (c)
			CH_BS:   r = CC_BS;
			CH_TAB:  r = CC_TAB;
			CH_LF:   r = CC_LF;
			CH_CR:   r = CC_CR;
			CH_ESC:  r = CC_ESC;
			CH_BEL:  r = CC_BEL;
			default: r = CC_PRINT;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/tccw_ifs.sv @@
`default_nettype none
interface tccw_req_if import tccw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [DATA_W-1:0] char_code;
	logic [ADDR_W-1:0] cell_address;

	modport source(output valid, opcode, char_code, cell_address, input ready);
	modport sink(input valid, opcode, char_code, cell_address, output ready);
endinterface

interface tccw_rsp_if import tccw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_value;
	logic [ADDR_W-1:0] cursor_index;

	modport source(output valid, cell_value, cursor_index, input ready);
	modport sink(input valid, cell_value, cursor_index, output ready);
endinterface
`default_nettype wire

@@ rtl/tccw_ctrl.sv @@
`default_nettype none
module tccw_ctrl import tccw_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire dp_sts_t  sts,
	output ctl_cmd_t      cmd
);

	ctl_state_t state_q, state_d;
	logic [2:0] tab_left_q, tab_left_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			tab_left_q <= '0;
		end else begin
			state_q    <= state_d;
			tab_left_q <= tab_left_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		tab_left_d = tab_left_q;
		case (state_q)
			ST_INIT: begin
				if (!sts.sweep_busy) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				tab_left_d = 3'd0;
				if (sts.op_read) begin
					state_d = sts.addr_ok ? ST_RDWAIT : ST_FINISH;
				end else begin
					case (sts.cclass)
						CC_TAB: begin
							tab_left_d = 3'd4;
							state_d    = ST_PUT;
						end
						CC_PRINT: begin
							tab_left_d = 3'd1;
							state_d    = ST_PUT;
						end
						CC_LF:   state_d = sts.on_last_row ? ST_SCROLL_COPY : ST_FINISH;
						CC_ESC:  state_d = ST_CLEAR;
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_RDWAIT: state_d = ST_FINISH;
			ST_PUT: begin
				tab_left_d = tab_left_q - 3'd1;
				if (sts.at_last_cell) state_d = ST_SCROLL_COPY;
				else if (tab_left_q == 3'd1) state_d = ST_FINISH;
			end
			ST_SCROLL_COPY: begin
				if (!sts.sweep_busy) state_d = ST_SCROLL_ROW;
			end
			ST_SCROLL_ROW: begin
				if (!sts.sweep_busy) state_d = (tab_left_q == 3'd0) ? ST_FINISH : ST_PUT;
			end
			ST_CLEAR: begin
				if (!sts.sweep_busy) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.load_item = req_valid;
			ST_EXEC: begin
				if (sts.op_read) begin
					cmd.rd_cell = sts.addr_ok;
				end else begin
					case (sts.cclass)
						CC_BS: begin
							cmd.cur_op        = CUR_BACK;
							cmd.wr_blank_back = 1'b1;
						end
						CC_LF: begin
							if (sts.on_last_row) begin
								cmd.cur_op = CUR_SCROLL;
								cmd.sweep  = SW_COPY;
							end else begin
								cmd.cur_op = CUR_LF;
							end
						end
						CC_CR: cmd.cur_op = CUR_CR;
						CC_ESC: begin
							cmd.cur_op = CUR_HOME;
							cmd.sweep  = SW_FILL_ALL;
						end
						default: cmd.cur_op = CUR_NONE;
					endcase
				end
			end
			ST_RDWAIT: cmd.cap_read = 1'b1;
			ST_PUT: begin
				cmd.wr_char  = 1'b1;
				cmd.wr_space = (sts.cclass == CC_TAB);
				if (sts.at_last_cell) begin
					cmd.cur_op = CUR_SCROLL;
					cmd.sweep  = SW_COPY;
				end else begin
					cmd.cur_op = CUR_ADV;
				end
			end
			ST_SCROLL_COPY: begin
				if (!sts.sweep_busy) cmd.sweep = SW_FILL_ROW;
			end
			ST_FINISH: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/tccw_dp.sv @@
`default_nettype none
module tccw_dp import tccw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [DATA_W-1:0] cfg_wdata,
	input  wire logic              req_opcode,
	input  wire logic [DATA_W-1:0] req_char,
	input  wire logic [ADDR_W-1:0] req_addr,
	input  wire logic              rsp_ready,
	output logic                   rsp_valid,
	output logic [CELL_W-1:0]      rsp_cell,
	output logic [ADDR_W-1:0]      rsp_cursor,
	input  wire ctl_cmd_t          cmd,
	output dp_sts_t                sts
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CAW   = $clog2(CELLS);
	localparam int COLW  = $clog2(COLUMNS);
	localparam int WIDE  = (CAW > ADDR_W) ? CAW : ADDR_W;

	localparam logic [CAW-1:0]  COLS_A    = CAW'(COLUMNS);
	localparam logic [CAW-1:0]  LAST_BASE = CAW'(CELLS - COLUMNS);
	localparam logic [CAW-1:0]  LAST_CELL = CAW'(CELLS - 1);
	localparam logic [CAW-1:0]  COPY_LAST = CAW'(CELLS - COLUMNS - 1);
	localparam logic [COLW-1:0] COL_MAX   = COLW'(COLUMNS - 1);

	typedef enum logic [1:0] {SM_IDLE, SM_FILL, SM_COPY} sw_mode_t;

	logic [DATA_W-1:0] attr_q;
	logic              op_q;
	logic [DATA_W-1:0] char_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CELL_W-1:0] result_q;

	logic [CAW-1:0]  cursor_q, cursor_d, base_q, base_d;
	logic [COLW-1:0] col_q, col_d;
	logic [CAW-1:0]  back_cursor, back_base;
	logic [COLW-1:0] back_col;

	sw_mode_t          sw_mode_q;
	logic [CAW-1:0]    sw_idx_q;
	logic [CELL_W-1:0] fill_val_q;
	logic              cp_wr_s1;
	logic [CAW-1:0]    cp_idx_s1;

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic              mem_we, mem_re;
	logic [CAW-1:0]    mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata;

	logic              rsp_valid_q;
	logic [CELL_W-1:0] rsp_cell_q;
	logic [ADDR_W-1:0] rsp_cursor_q;

	logic [WIDE-1:0]   addr_wide, cur_wide;
	logic [CELL_W-1:0] blank;

	assign blank     = {attr_q, {DATA_W{1'b0}}};
	assign addr_wide = WIDE'(addr_q);
	assign cur_wide  = WIDE'(cursor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= '0;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q     <= req_opcode;
			char_q   <= req_char;
			addr_q   <= req_addr;
			result_q <= '0;
		end else if (cmd.cap_read) begin
			result_q <= rdata_q;
		end
	end

	// backspace clamps at home
	always_comb begin
		back_cursor = cursor_q;
		back_base   = base_q;
		back_col    = col_q;
		if (cursor_q != '0) begin
			back_cursor = cursor_q - CAW'(1);
			if (col_q == '0) begin
				back_col  = COL_MAX;
				back_base = base_q - COLS_A;
			end else begin
				back_col = col_q - COLW'(1);
			end
		end
	end

	always_comb begin
		cursor_d = cursor_q;
		base_d   = base_q;
		col_d    = col_q;
		case (cmd.cur_op)
			CUR_ADV: begin
				cursor_d = cursor_q + CAW'(1);
				if (col_q == COL_MAX) begin
					col_d  = '0;
					base_d = base_q + COLS_A;
				end else begin
					col_d = col_q + COLW'(1);
				end
			end
			CUR_BACK: begin
				cursor_d = back_cursor;
				base_d   = back_base;
				col_d    = back_col;
			end
			CUR_LF: begin
				cursor_d = base_q + COLS_A;
				base_d   = base_q + COLS_A;
				col_d    = '0;
			end
			CUR_CR: begin
				cursor_d = base_q;
				col_d    = '0;
			end
			CUR_HOME: begin
				cursor_d = '0;
				base_d   = '0;
				col_d    = '0;
			end
			CUR_SCROLL: begin
				cursor_d = LAST_BASE;
				base_d   = LAST_BASE;
				col_d    = '0;
			end
			default: cursor_d = cursor_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			base_q   <= '0;
			col_q    <= '0;
		end else begin
			cursor_q <= cursor_d;
			base_q   <= base_d;
			col_q    <= col_d;
		end
	end

	// sweep engine: reset starts a zero fill of the whole screen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_mode_q  <= SM_FILL;
			sw_idx_q   <= '0;
			fill_val_q <= '0;
			cp_wr_s1   <= 1'b0;
			cp_idx_s1  <= '0;
		end else begin
			cp_wr_s1  <= (sw_mode_q == SM_COPY);
			cp_idx_s1 <= sw_idx_q;
			case (sw_mode_q)
				SM_FILL: begin
					if (sw_idx_q == LAST_CELL) sw_mode_q <= SM_IDLE;
					else sw_idx_q <= sw_idx_q + CAW'(1);
				end
				SM_COPY: begin
					if (sw_idx_q == COPY_LAST) sw_mode_q <= SM_IDLE;
					else sw_idx_q <= sw_idx_q + CAW'(1);
				end
				default: begin
					case (cmd.sweep)
						SW_FILL_ALL: begin
							sw_mode_q  <= SM_FILL;
							sw_idx_q   <= '0;
							fill_val_q <= blank;
						end
						SW_FILL_ROW: begin
							sw_mode_q  <= SM_FILL;
							sw_idx_q   <= LAST_BASE;
							fill_val_q <= blank;
						end
						SW_COPY: begin
							sw_mode_q <= SM_COPY;
							sw_idx_q  <= '0;
						end
						default: sw_mode_q <= SM_IDLE;
					endcase
				end
			endcase
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cursor_q;
		mem_wdata = {attr_q, cmd.wr_space ? CH_SPACE : char_q};
		if (cp_wr_s1) begin
			mem_we    = 1'b1;
			mem_waddr = cp_idx_s1;
			mem_wdata = rdata_q;
		end else if (sw_mode_q == SM_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = sw_idx_q;
			mem_wdata = fill_val_q;
		end else if (cmd.wr_char) begin
			mem_we = 1'b1;
		end else if (cmd.wr_blank_back) begin
			mem_we    = 1'b1;
			mem_waddr = back_cursor;
			mem_wdata = blank;
		end
		mem_re    = 1'b0;
		mem_raddr = addr_wide[CAW-1:0];
		if (sw_mode_q == SM_COPY) begin
			mem_re    = 1'b1;
			mem_raddr = sw_idx_q + COLS_A;
		end else if (cmd.rd_cell) begin
			mem_re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_cell_q   <= result_q;
			rsp_cursor_q <= cur_wide[ADDR_W-1:0];
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp_cell   = rsp_cell_q;
	assign rsp_cursor = rsp_cursor_q;

	assign sts.op_read      = op_q;
	assign sts.cclass       = char_class(char_q);
	assign sts.addr_ok      = 32'(addr_q) < 32'(CELLS);
	assign sts.at_last_cell = (cursor_q == LAST_CELL);
	assign sts.on_last_row  = (base_q == LAST_BASE);
	assign sts.sweep_busy   = (sw_mode_q != SM_IDLE) || cp_wr_s1;
	assign sts.out_free     = !rsp_valid_q || rsp_ready;

endmodule
`default_nettype wire

@@ rtl/text_console_char_writer.sv @@
// Text console character writer.
// req channel: one word per item. opcode 0 puts char_code at the cursor,
// opcode 1 reads the cell at cell_address. rsp channel: one word per item
// with the cell value (zero for a put) and the cursor after the item.
// cfg_we/cfg_wdata set the attribute byte. The user must see that it is
// written only while idle; the block itself does not enforce this.
// The next word is taken in the cycle after the response is loaded.
// A scroll copies the screen up one row through the single screen RAM port
// pair, one cell a cycle, then blanks the bottom row. Escape clears the
// whole screen.
// After reset a clearing pass zeroes the screen, one cell a cycle;
// req.ready stays low until it ends.
// The response sits in an output register; a new word is accepted while it
// waits, and the block holds its finished result while rsp.ready is low.
`default_nettype none
`include "text_console_char_writer_macros.svh"
module text_console_char_writer import tccw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [DATA_W-1:0] cfg_wdata,
	tccw_req_if.sink               req,
	tccw_rsp_if.source             rsp
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	tccw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tccw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_opcode (req.opcode),
		.req_char   (req.char_code),
		.req_addr   (req.cell_address),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.rsp_cell   (rsp.cell_value),
		.rsp_cursor (rsp.cursor_index),
		.cmd        (cmd),
		.sts        (sts)
	);

	`TCCW_ASSERT(a_ready_no_sweep, clk, arst_n, req.ready |-> !sts.sweep_busy)
	`TCCW_ASSERT(a_item_wr_no_sweep, clk, arst_n, (cmd.wr_char || cmd.wr_blank_back) |-> !sts.sweep_busy)
	`TCCW_ASSERT_NEXT(a_one_item, clk, arst_n, req.valid && req.ready, !req.ready)
	`TCCW_ASSERT_NEXT(a_read_capture, clk, arst_n, cmd.rd_cell, cmd.cap_read)

endmodule
`default_nettype wire

@@ tb/sv/text_console_char_writer_test.sv @@
`timescale 1ns / 1ps
module text_console_char_writer_test;
	import tccw_pkg::*;

	localparam int COLUMNS = COLUMNS_DEF;
	localparam int ROWS = ROWS_DEF;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int ADDR_TOP = (1 << ADDR_W) - 1;
	localparam logic OP_PUT = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam int ITEM_TARGET = 1350;
	localparam int PHASES = 6;
	localparam longint CYCLE_LIMIT = 64'd12_000_000;

	typedef struct {
		logic              opcode;
		logic [DATA_W-1:0] char_code;
		logic [ADDR_W-1:0] cell_address;
	} char_item_t;

	typedef struct {
		logic [CELL_W-1:0] cell_value;
		logic [ADDR_W-1:0] cursor_index;
	} console_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [DATA_W-1:0] cfg_wdata;

	tccw_req_if char_in();
	tccw_rsp_if cell_out();

	text_console_char_writer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (char_in),
		.rsp      (cell_out)
	);

	char_item_t        char_items_todo[$];
	console_word_t     words_due[$];
	logic [CELL_W-1:0] screen_copy[CELLS];
	int unsigned       cursor_pos = 0;
	logic [DATA_W-1:0] attr_byte = '0;
	int                fault_count = 0;
	int                words_checked = 0;
	int                puts_done = 0;
	int                reads_done = 0;
	int                scrolls_seen = 0;
	int                clears_seen = 0;
	int                attr_writes = 0;
	int                items_queued = 0;
	int                send_hold = 0;
	int                recv_hold = 0;
	longint            cycle_count = 0;
	bit                steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [CELL_W-1:0] blank_word();
		return {attr_byte, {DATA_W{1'b0}}};
	endfunction

	function automatic void scroll_when_full();
		int i;
		if (cursor_pos < CELLS)
			return;
		for (i = 0; i < CELLS - COLUMNS; i++)
			screen_copy[i] = screen_copy[i + COLUMNS];
		for (i = CELLS - COLUMNS; i < CELLS; i++)
			screen_copy[i] = blank_word();
		cursor_pos = CELLS - COLUMNS;
		scrolls_seen++;
	endfunction

	function automatic void write_cell_advance(input logic [DATA_W-1:0] c);
		if (cursor_pos < CELLS)
			screen_copy[cursor_pos] = {attr_byte, c};
		cursor_pos++;
		scroll_when_full();
	endfunction

	function automatic console_word_t console_step(input char_item_t it);
		console_word_t w;
		int i;
		w.cell_value = '0;
		if (it.opcode == OP_PUT) begin
			puts_done++;
			case (it.char_code)
				CH_BS: begin
					if (cursor_pos == 0)
						cursor_pos = 1;
					cursor_pos--;
					screen_copy[cursor_pos] = blank_word();
				end
				CH_TAB: begin
					repeat (4) write_cell_advance(CH_SPACE);
				end
				CH_LF: cursor_pos += COLUMNS - cursor_pos % COLUMNS;
				CH_CR: cursor_pos -= cursor_pos % COLUMNS;
				CH_ESC: begin
					for (i = 0; i < CELLS; i++)
						screen_copy[i] = blank_word();
					cursor_pos = 0;
					clears_seen++;
				end
				CH_BEL: ;
				default: write_cell_advance(it.char_code);
			endcase
			scroll_when_full();
		end else begin
			reads_done++;
			if (it.cell_address < CELLS)
				w.cell_value = screen_copy[it.cell_address];
		end
		w.cursor_index = cursor_pos[ADDR_W-1:0];
		return w;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ADDR_W-1:0] read_address();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return ADDR_W'($urandom_range(CELLS, ADDR_TOP));
		if (r < 4)
			return ADDR_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
		return ADDR_W'($urandom_range(0, CELLS - 1));
	endfunction

	function automatic logic [ADDR_W-1:0] any_address();
		return ADDR_W'($urandom_range(0, ADDR_TOP));
	endfunction

	function automatic logic [DATA_W-1:0] any_byte();
		return DATA_W'($urandom_range(0, 255));
	endfunction

	function automatic void queue_item(input logic op, input logic [DATA_W-1:0] c,
			input logic [ADDR_W-1:0] a);
		char_item_t it;
		it.opcode = op;
		it.char_code = c;
		it.cell_address = a;
		char_items_todo.push_back(it);
		items_queued++;
	endfunction

	function automatic void random_item();
		int r;
		logic [DATA_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			queue_item(OP_READ, any_byte(), read_address());
		end else begin
			r = $urandom_range(0, 99);
			if (r < 6)
				c = CH_LF;
			else if (r < 9)
				c = CH_CR;
			else if (r < 13)
				c = CH_BS;
			else if (r < 17)
				c = CH_TAB;
			else if (r < 19)
				c = CH_BEL;
			else if (r < 20)
				c = CH_ESC;
			else
				c = any_byte();
			queue_item(OP_PUT, c, any_address());
		end
	endfunction

	// a line of text, then a line ending (LF or CR LF) or a tab
	function automatic void text_line();
		int n;
		int r;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 40);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				queue_item(OP_PUT, any_byte(), any_address());
			else
				queue_item(OP_PUT, DATA_W'($urandom_range(32, 126)), any_address());
		end
		r = $urandom_range(0, 9);
		if (r < 7) begin
			queue_item(OP_PUT, CH_LF, any_address());
		end else if (r < 9) begin
			queue_item(OP_PUT, CH_CR, any_address());
			queue_item(OP_PUT, CH_LF, any_address());
		end else begin
			queue_item(OP_PUT, CH_TAB, any_address());
		end
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (char_items_todo.size() != 0 || words_due.size() != 0 || char_in.valid);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_attribute(input logic [DATA_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		attr_byte = v;
		attr_writes++;
	endtask

	// driver
	always @(posedge clk) begin
		char_item_t got;
		char_item_t nxt;
		if (!arst_n) begin
			char_in.valid <= 1'b0;
			send_hold = 0;
		end else begin
			if (char_in.valid && char_in.ready) begin
				got.opcode = char_in.opcode;
				got.char_code = char_in.char_code;
				got.cell_address = char_in.cell_address;
				words_due.push_back(console_step(got));
			end
			if (!char_in.valid || char_in.ready) begin
				if (send_hold > 0) begin
					send_hold--;
					char_in.valid <= 1'b0;
				end else if (char_items_todo.size() > 0) begin
					nxt = char_items_todo.pop_front();
					char_in.valid <= 1'b1;
					char_in.opcode <= nxt.opcode;
					char_in.char_code <= nxt.char_code;
					char_in.cell_address <= nxt.cell_address;
					send_hold = pick_gap();
				end else begin
					char_in.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		console_word_t want;
		if (!arst_n) begin
			cell_out.ready <= 1'b0;
			recv_hold = 0;
		end else begin
			if (cell_out.valid && cell_out.ready) begin
				words_checked++;
				if (words_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 40)
						$display("%0t: unexpected word cell_value %h cursor_index %0d", $time,
							cell_out.cell_value, cell_out.cursor_index);
				end else begin
					want = words_due.pop_front();
					if (cell_out.cell_value !== want.cell_value) begin
						fault_count++;
						if (fault_count <= 40)
							$display("%0t: cell_value expected %h actual %h", $time,
								want.cell_value, cell_out.cell_value);
					end
					if (cell_out.cursor_index !== want.cursor_index) begin
						fault_count++;
						if (fault_count <= 40)
							$display("%0t: cursor_index expected %0d actual %0d", $time,
								want.cursor_index, cell_out.cursor_index);
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				cell_out.ready <= 1'b0;
			end else begin
				recv_hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
				cell_out.ready <= (recv_hold == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int p;
		int r;
		int quota;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		char_in.valid = 1'b0;
		char_in.opcode = OP_PUT;
		char_in.char_code = '0;
		char_in.cell_address = '0;
		cell_out.ready = 1'b0;
		for (p = 0; p < CELLS; p++)
			screen_copy[p] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		set_attribute(8'h07);
		queue_item(OP_PUT, CH_BS, '0);
		queue_item(OP_READ, '0, '0);
		queue_item(OP_PUT, 8'h41, '0);
		queue_item(OP_PUT, 8'hFF, '0);
		queue_item(OP_PUT, 8'h00, '0);
		queue_item(OP_PUT, 8'h80, '0);
		queue_item(OP_PUT, CH_BEL, '0);
		queue_item(OP_PUT, CH_TAB, '0);
		queue_item(OP_READ, '0, 11'd1);
		queue_item(OP_READ, 8'hFF, 11'd2);
		queue_item(OP_PUT, CH_CR, '0);
		queue_item(OP_PUT, CH_LF, '0);
		queue_item(OP_PUT, CH_BS, '0);
		queue_item(OP_PUT, CH_LF, ADDR_W'(ADDR_TOP));
		queue_item(OP_READ, '0, ADDR_W'(COLUMNS - 1));
		queue_item(OP_READ, '0, ADDR_W'(CELLS - 1));
		queue_item(OP_READ, '0, ADDR_W'(CELLS));
		queue_item(OP_READ, 8'hFF, ADDR_W'(ADDR_TOP));
		queue_item(OP_PUT, CH_ESC, '0);
		queue_item(OP_READ, '0, 11'd1);
		queue_item(OP_PUT, 8'h7F, ADDR_W'(ADDR_TOP));

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0, 4: set_attribute(8'hFF);
				2: set_attribute(8'h00);
				default: set_attribute(DATA_W'($urandom_range(1, 254)));
			endcase
			steady = (p == 3);
			quota = items_queued + (ITEM_TARGET - 21) / PHASES;
			while (items_queued < quota) begin
				r = $urandom_range(0, 9);
				if (r < 5)
					random_item();
				else if (r < 8)
					text_line();
				else
					repeat ($urandom_range(1, 6))
						queue_item(OP_READ, any_byte(), read_address());
			end
		end
		wait_drained();
		repeat (20) @(posedge clk);

		$display("tb: %0d words checked: %0d puts, %0d reads", words_checked, puts_done,
			reads_done);
		$display("tb: %0d scrolls, %0d screen clears, %0d attribute writes", scrolls_seen,
			clears_seen, attr_writes);
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
